// ===== sv/preemptive_priority_scheduler_top_assert.svh =====
// ----------------------------------------------------------------------------
// Preemptive priority scheduler assertion macros
// Shorthand for the concurrent checks at the end of the top level. Each macro
// expects clk and rst_n in scope and is disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_TOP_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_TOP_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define PPS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define PPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Request and result types, table entry layout and sequencer states.
// ----------------------------------------------------------------------------
package pps_pkg;

  // Request kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // The time counter saturates here.
  localparam logic [15:0] TIME_MAX = 16'hFFFF;

  typedef struct packed {
    logic        kind;
    logic [15:0] arrival_time;
    logic [15:0] burst_length;
    logic [7:0]  priority_level;
  } in_req_t;

  typedef struct packed {
    logic [15:0] tick_time;
    logic        idle;
    logic [3:0]  running_slot;
    logic        switched;
    logic        finished;
    logic [15:0] finish_time;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic        all_done;
  } out_res_t;

  // One process as held in the table memory.
  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [7:0]  prio;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_COMMIT
  } pps_state_t;

  // What ran on the previous tick.
  typedef enum logic [1:0] {
    PREV_NONE,
    PREV_IDLE,
    PREV_SLOT
  } prev_kind_t;

endpackage

// ===== sv/pps_table.sv =====
// ----------------------------------------------------------------------------
// Process table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pps_table #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  pps_pkg::entry_t  wr_data,
  input  logic [AW-1:0]    rd_addr,
  output pps_pkg::entry_t  rd_data
);
  import pps_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/preemptive_priority_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Tick-driven scheduler that holds a table of processes and on every tick
// runs the ready process with the lowest priority number.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                         Direction  Moves
//   input    in_valid, in_stall, in_req    in         load or tick request
//   output   out_valid, out_stall, out_res out        one result per tick
//
// A load request gives no result. A tick request is accepted, then reads
// the table once per loaded slot, waits out the read latency, sees the last
// read drain, forms the turnaround and commits. The single read port of the
// process table makes the slots be read one after another.
// Reset clears the counts, the time and the sequencer; the table itself is
// never cleared, since only slots below the loaded count are read.
// in_stall is high while a tick is being worked on. A finished result waits
// in the output register while the next request is taken; a tick only stalls
// at its commit step while the previous result is still held.
module preemptive_priority_scheduler_top #(
  parameter int MAX_PROCESSES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pps_pkg::in_req_t   in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output pps_pkg::out_res_t  out_res
);
  import pps_pkg::*;

  // Counts must hold MAX_PROCESSES itself; slot indices need one less.
  localparam int CW = $clog2(MAX_PROCESSES + 1);
  localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PROCESSES);

  pps_state_t       state_r, state_nxt;
  logic [CW-1:0]    loaded_r, loaded_nxt;
  logic [CW-1:0]    completed_r, completed_nxt;
  logic [15:0]      time_r, time_nxt;
  prev_kind_t       prev_kind_r, prev_kind_nxt;
  logic [IW-1:0]    prev_slot_r, prev_slot_nxt;

  logic [CW-1:0]    scan_idx_r, scan_idx_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]    rd_slot_r, rd_slot_nxt;
  logic             found_r, found_nxt;
  logic [IW-1:0]    best_slot_r, best_slot_nxt;
  entry_t           best_ent_r, best_ent_nxt;
  logic [15:0]      tat_r, tat_nxt;

  logic             out_valid_r, out_valid_nxt;
  out_res_t         out_res_r, out_res_nxt;

  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  entry_t           wr_data;
  entry_t           rd_data;

  logic             in_fire;
  logic             out_free;
  logic             clr;
  logic [CW-1:0]    base_loaded;
  logic [CW-1:0]    base_completed;
  logic [15:0]      time_inc;
  logic [15:0]      rem_dec;
  logic             fin;
  logic             same_run;
  logic [CW-1:0]    done_cnt;

  pps_table #(
    .DEPTH (MAX_PROCESSES),
    .AW    (IW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (scan_idx_r[IW-1:0]),
    .rd_data (rd_data)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // A load that finds every loaded process finished starts a fresh table.
  assign clr            = (completed_r == loaded_r);
  assign base_loaded    = clr ? '0 : loaded_r;
  assign base_completed = clr ? '0 : completed_r;

  assign time_inc = (time_r == TIME_MAX) ? TIME_MAX : time_r + 16'd1;
  assign rem_dec  = best_ent_r.remaining - 16'd1;
  assign fin      = found_r && (rem_dec == 16'd0);
  assign done_cnt = completed_r + (fin ? CW'(1) : CW'(0));
  assign same_run = found_r ? (prev_kind_r == PREV_SLOT && prev_slot_r == best_slot_r)
                            : (prev_kind_r == PREV_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      loaded_r    <= '0;
      completed_r <= '0;
      time_r      <= '0;
      prev_kind_r <= PREV_NONE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      completed_r <= completed_nxt;
      time_r      <= time_nxt;
      prev_kind_r <= prev_kind_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_slot_r <= prev_slot_nxt;
    scan_idx_r  <= scan_idx_nxt;
    rd_slot_r   <= rd_slot_nxt;
    found_r     <= found_nxt;
    best_slot_r <= best_slot_nxt;
    best_ent_r  <= best_ent_nxt;
    tat_r       <= tat_nxt;
    out_res_r   <= out_res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    completed_nxt = completed_r;
    time_nxt      = time_r;
    prev_kind_nxt = prev_kind_r;
    prev_slot_nxt = prev_slot_r;
    scan_idx_nxt  = scan_idx_r;
    rd_vld_nxt    = 1'b0;
    rd_slot_nxt   = rd_slot_r;
    found_nxt     = found_r;
    best_slot_nxt = best_slot_r;
    best_ent_nxt  = best_ent_r;
    tat_nxt       = tat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;
    wr_en         = 1'b0;
    wr_addr       = best_slot_r;
    wr_data       = best_ent_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_req.kind == KIND_LOAD) begin
            if (clr) begin
              time_nxt      = '0;
              prev_kind_nxt = PREV_NONE;
            end
            loaded_nxt    = base_loaded;
            completed_nxt = base_completed;
            // A full table ignores the load.
            if (base_loaded < MAX_CNT) begin
              wr_en             = 1'b1;
              wr_addr           = base_loaded[IW-1:0];
              wr_data.arrival   = in_req.arrival_time;
              wr_data.burst     = in_req.burst_length;
              wr_data.remaining = in_req.burst_length;
              wr_data.prio      = in_req.priority_level;
              loaded_nxt        = base_loaded + CW'(1);
              if (in_req.burst_length == 16'd0) begin
                completed_nxt = base_completed + CW'(1);
              end
            end
          end else begin
            scan_idx_nxt = '0;
            found_nxt    = 1'b0;
            state_nxt    = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle; judge the entry read the cycle before.
        if (scan_idx_r < loaded_r) begin
          rd_vld_nxt   = 1'b1;
          rd_slot_nxt  = scan_idx_r[IW-1:0];
          scan_idx_nxt = scan_idx_r + CW'(1);
        end else if (!rd_vld_r) begin
          state_nxt = ST_CALC;
        end
        if (rd_vld_r && rd_data.arrival <= time_r && rd_data.remaining != 16'd0 &&
            (!found_r || rd_data.prio < best_ent_r.prio)) begin
          found_nxt     = 1'b1;
          best_slot_nxt = rd_slot_r;
          best_ent_nxt  = rd_data;
        end
      end

      ST_CALC: begin
        tat_nxt   = time_inc - best_ent_r.arrival;
        state_nxt = ST_COMMIT;
      end

      ST_COMMIT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_res_nxt.tick_time    = time_r;
          out_res_nxt.idle         = !found_r;
          out_res_nxt.running_slot = found_r ? 4'(best_slot_r) : 4'd0;
          out_res_nxt.switched     = !same_run;
          out_res_nxt.finished     = fin;
          out_res_nxt.finish_time  = fin ? time_inc : 16'd0;
          out_res_nxt.turnaround   = fin ? tat_r : 16'd0;
          out_res_nxt.waiting      = (fin && tat_r >= best_ent_r.burst) ?
                                     tat_r - best_ent_r.burst : 16'd0;
          out_res_nxt.all_done     = (done_cnt == loaded_r);

          time_nxt      = time_inc;
          completed_nxt = done_cnt;
          prev_kind_nxt = found_r ? PREV_SLOT : PREV_IDLE;
          prev_slot_nxt = best_slot_r;
          if (found_r) begin
            wr_en             = 1'b1;
            wr_addr           = best_slot_r;
            wr_data.remaining = rem_dec;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Checks on the scheduler's own bookkeeping.
  `include "preemptive_priority_scheduler_top_assert.svh"

  `PPS_ASSERT_ALWAYS(a_counts_ordered, completed_r <= loaded_r && loaded_r <= MAX_CNT, "completed count exceeds loaded count or table size")
  `PPS_ASSERT_SAME(a_read_in_range, rd_vld_r, CW'(rd_slot_r) < loaded_r, "table read beyond loaded slots")
  `PPS_ASSERT_NEXT(a_commit_shows, state_r == ST_COMMIT && out_free, out_valid_r && state_r == ST_IDLE, "tick commit did not present a result")
  `PPS_ASSERT_SAME(a_finish_not_idle, out_valid_r, !(out_res_r.finished && out_res_r.idle), "idle result reports a finished process")

endmodule

// ===== test/tb_preemptive_priority_scheduler_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler testbench
// Drives load and tick requests into the scheduler and checks every tick
// result against a cycle-free prediction of the process table kept in a
// small scoreboard. Covers empty and finished tables, zero bursts, priority
// ties and a full table.
// ----------------------------------------------------------------------------
module tb_preemptive_priority_scheduler_top;
  import pps_pkg::*;

  localparam int MAX_SLOTS    = 16;
  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 8;
  // A tick reads each loaded slot once and the random stalls are short,
  // so this leaves a wide margin.
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 1550;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the process table and predicts the
  // result of every tick request at the moment the request is accepted.
  // --------------------------------------------------------------------------
  class sched_scoreboard;
    logic [15:0] arrival_at [MAX_SLOTS];
    logic [15:0] burst_of   [MAX_SLOTS];
    logic [15:0] work_left  [MAX_SLOTS];
    logic [7:0]  prio_of    [MAX_SLOTS];
    int          loaded;
    int          completed;
    logic [15:0] now_time;
    prev_kind_t  last_kind;
    logic [3:0]  last_slot;
    out_res_t    expected_ticks [$];
    int          checked;
    int          mismatches;
    int          strays;

    function new();
      clear_table();
      checked    = 0;
      mismatches = 0;
      strays     = 0;
    endfunction

    function void clear_table();
      for (int i = 0; i < MAX_SLOTS; i++) begin
        arrival_at[i] = '0;
        burst_of[i]   = '0;
        work_left[i]  = '0;
        prio_of[i]    = '0;
      end
      loaded    = 0;
      completed = 0;
      now_time  = '0;
      last_kind = PREV_NONE;
      last_slot = '0;
    endfunction

    function bit all_finished();
      return completed == loaded;
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction

    function void note_request(in_req_t r);
      out_res_t    want;
      logic [15:0] start;
      logic [15:0] tat;
      bit          found;
      int          best;
      logic [7:0]  best_prio;

      if (r.kind == KIND_LOAD) begin
        // A load into a table with nothing left to run starts a new set.
        if (completed == loaded) clear_table();
        if (loaded < MAX_SLOTS) begin
          arrival_at[loaded] = r.arrival_time;
          burst_of[loaded]   = r.burst_length;
          work_left[loaded]  = r.burst_length;
          prio_of[loaded]    = r.priority_level;
          loaded++;
          if (r.burst_length == '0) completed++;
        end
        return;
      end

      start     = now_time;
      found     = 1'b0;
      best      = 0;
      best_prio = '0;
      for (int i = 0; i < loaded; i++) begin
        if (arrival_at[i] <= start && work_left[i] != '0 &&
            (!found || prio_of[i] < best_prio)) begin
          found     = 1'b1;
          best      = i;
          best_prio = prio_of[i];
        end
      end

      want              = '0;
      want.tick_time    = start;
      want.idle         = !found;
      want.running_slot = found ? 4'(best) : 4'd0;
      if (found) begin
        want.switched = (last_kind != PREV_SLOT) || (last_slot != 4'(best));
        last_kind     = PREV_SLOT;
        last_slot     = 4'(best);
      end else begin
        want.switched = (last_kind != PREV_IDLE);
        last_kind     = PREV_IDLE;
      end
      now_time = (start == TIME_MAX) ? start : start + 16'd1;

      if (found) begin
        work_left[best] = work_left[best] - 16'd1;
        if (work_left[best] == '0) begin
          completed++;
          tat              = now_time - arrival_at[best];
          want.finished    = 1'b1;
          want.finish_time = now_time;
          want.turnaround  = tat;
          // Only a saturated clock can make the wait come out negative.
          want.waiting     = (tat >= burst_of[best]) ? tat - burst_of[best] : 16'd0;
        end
      end
      want.all_done = (completed == loaded);
      expected_ticks.push_back(want);
    endfunction

    function string show(out_res_t v);
      return $sformatf("t=%0d idle=%b slot=%0d sw=%b fin=%b ft=%0d tat=%0d wt=%0d done=%b",
                       v.tick_time, v.idle, v.running_slot, v.switched, v.finished,
                       v.finish_time, v.turnaround, v.waiting, v.all_done);
    endfunction

    function void check_result(out_res_t got);
      out_res_t want;
      bit       bad;

      checked++;
      if (expected_ticks.size() == 0) begin
        strays++;
        if (mismatches + strays <= 10)
          $display("result %0d arrived with no tick pending: %s", checked, show(got));
        return;
      end
      want = expected_ticks.pop_front();
      bad  = (got.tick_time    !== want.tick_time)    ||
             (got.idle         !== want.idle)         ||
             (got.running_slot !== want.running_slot) ||
             (got.switched     !== want.switched)     ||
             (got.finished     !== want.finished)     ||
             (got.finish_time  !== want.finish_time)  ||
             (got.turnaround   !== want.turnaround)   ||
             (got.waiting      !== want.waiting)      ||
             (got.all_done     !== want.all_done);
      if (bad) begin
        mismatches++;
        if (mismatches + strays <= 10) begin
          $display("result %0d mismatch", checked);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction

    function int failures();
      if (expected_ticks.size() != 0)
        $display("%0d tick results never arrived", expected_ticks.size());
      return mismatches + strays + expected_ticks.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test and its stimulus signals.
  // --------------------------------------------------------------------------
  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_stall;
  out_res_t out_res;

  sched_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int items_sent;
  int quiet_cycles;

  preemptive_priority_scheduler_top #(.MAX_PROCESSES(MAX_SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // The receiver decides at each falling edge whether to hold off the next
  // result; results are taken at the rising edge when valid and not stalled.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_res);
  end

  // Watchdog: the run is stuck if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("no request or result moved for %0d cycles", IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Request building and driving. Every task is entered and left at a
  // falling edge, so in_valid gets at most one assignment per time step and
  // stays high across back-to-back requests.
  // --------------------------------------------------------------------------
  function automatic in_req_t make_load(logic [15:0] arrival, logic [15:0] burst,
                                        logic [7:0] prio);
    in_req_t r;
    r.kind           = KIND_LOAD;
    r.arrival_time   = arrival;
    r.burst_length   = burst;
    r.priority_level = prio;
    return r;
  endfunction

  // Ticks carry random junk in the load fields; the block must ignore it.
  function automatic in_req_t make_tick();
    in_req_t r;
    r.kind           = KIND_TICK;
    r.arrival_time   = 16'($urandom);
    r.burst_length   = 16'($urandom);
    r.priority_level = 8'($urandom);
    return r;
  endfunction

  function automatic in_req_t random_load(int max_arrival, int max_prio, bit zero_burst);
    logic [15:0] burst;
    if (zero_burst || $urandom_range(0, 7) == 0)
      burst = '0;
    else if ($urandom_range(0, 9) == 0)
      burst = 16'($urandom_range(7, 20));
    else
      burst = 16'($urandom_range(1, 6));
    return make_load(16'($urandom_range(0, max_arrival)), burst,
                     8'($urandom_range(0, max_prio)));
  endfunction

  task automatic send_request(input in_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    items_sent++;
    @(negedge clk);
  endtask

  // One set of processes: loads, then ticks until every process is done,
  // with the odd load slipped in while the set is still running and a few
  // idle ticks at the end.
  task automatic run_batch();
    int style;
    int n_loads;
    int max_arrival;
    int max_prio;

    style       = $urandom_range(0, 9);
    max_arrival = ($urandom_range(0, 1) != 0) ? 3 : 40;
    max_prio    = ($urandom_range(0, 1) != 0) ? 3 : 255;
    if (style == 0)
      n_loads = $urandom_range(MAX_SLOTS, MAX_SLOTS + 3);  // overfill the table
    else if (style <= 3)
      n_loads = $urandom_range(1, MAX_SLOTS);
    else
      n_loads = $urandom_range(1, 6);
    // With only zero bursts every load finds the table finished and clears it.
    for (int i = 0; i < n_loads; i++)
      send_request(random_load(max_arrival, max_prio, style == 1));
    while (!sb.all_finished()) begin
      if ($urandom_range(0, 19) == 0)
        send_request(random_load(max_arrival, max_prio, 1'b0));
      else
        send_request(make_tick());
    end
    repeat ($urandom_range(0, 3)) send_request(make_tick());
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int random_start;
    int done_random;

    sb             = new();
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req         = '0;
    out_stall      = 1'b0;
    items_sent     = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 33;
    recv_stall_pct = 83;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Ticks on an empty table: idle, everything done, and only the first
    // one counts as a switch.
    send_request(make_tick());
    send_request(make_tick());
    // A zero-burst process is complete as soon as it is loaded, so the
    // next load clears the table again.
    send_request(make_load(16'd0, 16'd0, 8'd255));
    send_request(make_load(16'd2, 16'd2, 8'd255));
    send_request(make_load(16'd0, 16'd1, 8'd5));
    send_request(make_load(16'd1, 16'd2, 8'd5));
    // Best priority but no work: must never be picked.
    send_request(make_load(16'd0, 16'd0, 8'd0));
    // Ties with slot 2 on priority and arrival; the lower slot wins.
    send_request(make_load(16'd1, 16'd1, 8'd5));
    // The low-priority process arrives at time 2 and must wait for the
    // priority 5 processes, then run to the end, then the table goes idle.
    repeat (8) send_request(make_tick());

    // Random sets of processes under the three idling patterns.
    random_start = items_sent;
    done_random  = 0;
    while (done_random < RANDOM_ITEMS) begin
      if (done_random >= (2 * RANDOM_ITEMS) / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end else if (done_random >= RANDOM_ITEMS / 3) begin
        send_idle_pct  = 83;
        recv_stall_pct = 33;
      end
      run_batch();
      done_random = items_sent - random_start;
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/pps_pkg.sv
sv/pps_table.sv
sv/preemptive_priority_scheduler_top.sv
test/tb_preemptive_priority_scheduler_top.sv
